// ===== rtl/core/psg_tone_noise_generator_unit_defines.svh =====
// Assertion macros shared by the PSG tone/noise generator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, gated off during reset
`define PSGTN_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("psgtn: same-cycle check failed");

// next-cycle implication, gated off during reset
`define PSGTN_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("psgtn: next-cycle check failed");

`endif

// ===== rtl/core/psgtn_pkg.sv =====
// Shared types, constants and the volume table for the PSG tone/noise generator.
// No dependencies.
package psgtn_pkg;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef logic [3:0]  atten_t;
  typedef logic [9:0]  period_t;
  typedef logic [15:0] count_t;
  typedef logic [12:0] vol_t;

  localparam logic [1:0]  NOISE_CH   = 2'd3;
  localparam logic [15:0] NOISE_TAPS = 16'h0009;
  localparam logic [15:0] NOISE_SEED = 16'h8000;
  localparam logic [15:0] NOISE_BASE = 16'h0010;
  localparam logic [1:0]  RATE_TONE2 = 2'd3;

  // what the mixer sees of each channel
  typedef struct packed {
    logic [3:0][3:0] atten;
    logic [3:0]      polarity;
  } chan_view_t;

  function automatic vol_t vol_level(input atten_t a);
    vol_t v;
    case (a)
      4'd0:    v = 13'd8191;
      4'd1:    v = 13'd6507;
      4'd2:    v = 13'd5168;
      4'd3:    v = 13'd4105;
      4'd4:    v = 13'd3261;
      4'd5:    v = 13'd2590;
      4'd6:    v = 13'd2057;
      4'd7:    v = 13'd1642;
      4'd8:    v = 13'd1298;
      4'd9:    v = 13'd1031;
      4'd10:   v = 13'd819;
      4'd11:   v = 13'd650;
      4'd12:   v = 13'd516;
      4'd13:   v = 13'd410;
      4'd14:   v = 13'd326;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/psg_tone_noise_generator_unit.sv =====
// Top level of the PSG tone/noise generator: input register, chip state,
// mixer and result register. Depends on psgtn_pkg, psgtn_regs, psgtn_mix.
//
//  channel  | direction | tdata           | tuser
//  ---------+-----------+-----------------+---------
//  s_axis   | in        | [7:0] data_byte | [0] func
//  m_axis   | out       | [15:0] mixed_sample (signed) | -
//
// One request per cycle unless the result stalls.
// The state update and mix are combinational between the input and
// result registers. Reset clears all chip state (volumes loud, polarity low,
// LFSR zero). A stalled result holds the input register; the input side
// stays ready while that register is empty.
`include "psg_tone_noise_generator_unit_defines.svh"

module psg_tone_noise_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] mixed_sample
);
  import psgtn_pkg::*;

  logic               in_valid;
  func_t              in_func;
  logic [7:0]         in_data;
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               advance;
  chan_view_t         chan_next;
  logic signed [15:0] mix_sample;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= func_t'(s_axis_tuser);
      in_data <= s_axis_tdata;
    end
    if (advance) begin
      out_sample <= mix_sample;
    end
  end

  psgtn_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .func      (in_func),
    .data_byte (in_data),
    .view      (chan_next)
  );

  psgtn_mix u_mix (
    .view   (chan_next),
    .sample (mix_sample)
  );

  `PSGTN_ASSERT_NEXT(a_adv_fills_out, clk, rst, advance, out_valid)
  `PSGTN_ASSERT_IMP(a_empty_ready, clk, rst, !in_valid, s_axis_tready)
  `PSGTN_ASSERT_NEXT(a_stall_holds_in, clk, rst, in_valid && !advance,
    in_valid && $stable(in_data))

endmodule

// ===== rtl/core/psgtn_regs.sv =====
// Chip register file, tone counters and noise LFSR of the PSG generator.
// Depends on psgtn_pkg and the assertion macro header.
`include "psg_tone_noise_generator_unit_defines.svh"

module psgtn_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  psgtn_pkg::func_t       func,
  input  logic [7:0]             data_byte,
  output psgtn_pkg::chan_view_t  view
);
  import psgtn_pkg::*;

  period_t [3:0] period, period_next;
  count_t  [3:0] counter, counter_next;
  atten_t  [3:0] atten, atten_next;
  logic    [3:0] polarity, polarity_next;
  logic [15:0]   noise, noise_next;
  logic [1:0]    latched_ch, latched_ch_next;
  logic          latched_vol, latched_vol_next;

  count_t [3:0]  cnt_dec;
  logic          latch;
  logic [1:0]    ch;
  logic          is_vol;
  logic [1:0]    rate;
  logic          fb;
  count_t        noise_reload;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_dec[i] = counter[i] - 16'd1;
    end
    latch  = data_byte[7];
    ch     = latch ? data_byte[6:5] : latched_ch;
    is_vol = latch ? data_byte[4] : latched_vol;
    rate   = period[3][1:0];
    case (rate)
      RATE_TONE2: noise_reload = {6'd0, period[2]};
      default:    noise_reload = NOISE_BASE << rate;
    endcase
    // white noise taps bits 0 and 3, periodic recirculates bit 0
    fb = period[3][2] ? ^(noise & NOISE_TAPS) : noise[0];
  end

  always_comb begin
    period_next      = period;
    counter_next     = counter;
    atten_next       = atten;
    polarity_next    = polarity;
    noise_next       = noise;
    latched_ch_next  = latched_ch;
    latched_vol_next = latched_vol;
    if (step) begin
      if (func == FUNC_TICK) begin
        for (int i = 0; i < 3; i++) begin
          counter_next[i] = cnt_dec[i];
          if (cnt_dec[i] == 16'd0) begin
            counter_next[i]  = {6'd0, period[i]};
            polarity_next[i] = ~polarity[i];
          end
        end
        counter_next[3] = cnt_dec[3];
        if (cnt_dec[3] == 16'd0) begin
          counter_next[3]  = noise_reload;
          noise_next       = {fb, noise[15:1]};
          polarity_next[3] = noise[1];
        end
      end else begin
        latched_ch_next  = ch;
        latched_vol_next = is_vol;
        if (is_vol) begin
          atten_next[ch] = data_byte[3:0];
        end else if (latch && ch == NOISE_CH) begin
          period_next[3] = {7'd0, data_byte[2:0]};
          noise_next     = NOISE_SEED;
        end else if (latch) begin
          period_next[ch] = {period[ch][9:4], data_byte[3:0]};
        end else begin
          period_next[ch]  = {data_byte[5:0], period[ch][3:0]};
          counter_next[ch] = {6'd0, data_byte[5:0], period[ch][3:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period      <= '0;
      counter     <= '0;
      atten       <= '0;
      polarity    <= '0;
      noise       <= '0;
      latched_ch  <= '0;
      latched_vol <= 1'b0;
    end else begin
      period      <= period_next;
      counter     <= counter_next;
      atten       <= atten_next;
      polarity    <= polarity_next;
      noise       <= noise_next;
      latched_ch  <= latched_ch_next;
      latched_vol <= latched_vol_next;
    end
  end

  assign view.atten    = atten_next;
  assign view.polarity = polarity_next;

  `PSGTN_ASSERT_NEXT(a_noise_reseed, clk, rst,
    step && func == FUNC_WRITE && data_byte[7] && data_byte[6:5] == NOISE_CH && !data_byte[4],
    noise == NOISE_SEED)
  `PSGTN_ASSERT_NEXT(a_write_keeps_pol, clk, rst, step && func == FUNC_WRITE,
    polarity == $past(polarity))
  `PSGTN_ASSERT_NEXT(a_idle_keeps_cnt, clk, rst, !step, $stable(counter))

endmodule

// ===== rtl/core/psgtn_mix.sv =====
// Four-channel mixer: signed sum of table volumes per channel polarity.
// Depends on psgtn_pkg.
module psgtn_mix (
  input  psgtn_pkg::chan_view_t view,
  output logic signed [15:0]    sample
);
  import psgtn_pkg::*;

  logic signed [3:0][15:0] term;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term[i] = view.polarity[i] ? {3'd0, vol_level(view.atten[i])}
                                 : -{3'd0, vol_level(view.atten[i])};
    end
    sample = (term[0] + term[1]) + (term[2] + term[3]);
  end

endmodule
